// File: rtl/daet_pkg.sv
// Shared types and constants for the device access exception table.
// No dependencies. The controller, datapath and top level use it.
`default_nettype none
package daet_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [31:0] ANY_NUM = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  typ;
    logic [31:0] major;
    logic [31:0] minor;
    logic [2:0]  access;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture request, clear accumulators
    logic scan_rd;  // read the entry at the sweep address
    logic wipe_wr;  // write a free entry at the sweep address
    logic finish;   // insert if needed, register the result
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// File: rtl/daet_ctrl.sv
// Sequencer for the exception table: memory wipe (after reset and on clear), table scan, finish.
// Depends on daet_pkg; drives daet_datapath through ctrl_cmd_t.
`default_nettype none
module daet_ctrl #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [1:0]                     cmd,
  output logic                                busy,
  output daet_pkg::ctrl_cmd_t                 ctrl,
  output logic [$clog2(TABLE_DEPTH)-1:0]      addr
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_WIPE   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]    state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic          reply, reply_next;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    reply_next   = reply;
    ctrl.load    = 1'b0;
    ctrl.scan_rd = 1'b0;
    ctrl.wipe_wr = 1'b0;
    ctrl.finish  = 1'b0;
    unique case (state)
      S_WIPE: begin
        ctrl.wipe_wr = 1'b1;
        idx_next     = idx + AW'(1);
        if (idx == LAST) begin
          state_next = reply ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        idx_next = '0;
        if (start) begin
          ctrl.load  = 1'b1;
          reply_next = 1'b1;
          state_next = (cmd == daet_pkg::CMD_CLEAR) ? S_WIPE : S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.scan_rd = 1'b1;
        idx_next     = idx + AW'(1);
        if (idx == LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctrl.finish = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      idx   <= '0;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      reply <= reply_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign addr = idx;

endmodule
`default_nettype wire

// File: rtl/daet_datapath.sv
// Entry memory, per-entry match logic, scan accumulators and result registers.
// Depends on daet_pkg; sequenced by daet_ctrl.
`default_nettype none
module daet_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire daet_pkg::ctrl_cmd_t        ctrl,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] addr,
  input  wire logic                       default_allow,
  input  wire logic [1:0]                 cmd,
  input  wire logic [1:0]                 dev_type,
  input  wire logic [31:0]                major_num,
  input  wire logic [31:0]                minor_num,
  input  wire logic [2:0]                 access_mask,
  output logic                            done,
  output logic                            status,
  output logic                            allowed
);

  localparam int AW = $clog2(TABLE_DEPTH);

  daet_pkg::entry_t mem [TABLE_DEPTH];
  daet_pkg::entry_t rd_q;

  // latched request
  logic [1:0]  req_cmd;
  logic [1:0]  req_type;
  logic [31:0] req_major;
  logic [31:0] req_minor;
  logic [2:0]  req_acc;

  logic          eval_vld;
  logic [AW-1:0] eval_addr;

  logic          hit;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          any_partial;
  logic          any_full;

  logic             used, type_ok, key_eq, part_m, full_m;
  logic             we;
  logic [AW-1:0]    wa;
  daet_pkg::entry_t wd;
  logic             is_add, is_remove, do_insert;

  assign is_add    = (req_cmd == daet_pkg::CMD_ADD);
  assign is_remove = (req_cmd == daet_pkg::CMD_REMOVE);

  always_comb begin
    used    = (rd_q.access != 3'd0);
    type_ok = ((req_type & ~rd_q.typ) == 2'd0);
    key_eq  = used && (rd_q.typ == req_type) && (rd_q.major == req_major) &&
              (rd_q.minor == req_minor);
    part_m  = used && type_ok &&
              (rd_q.major == daet_pkg::ANY_NUM || req_major == daet_pkg::ANY_NUM ||
               rd_q.major == req_major) &&
              (rd_q.minor == daet_pkg::ANY_NUM || req_minor == daet_pkg::ANY_NUM ||
               rd_q.minor == req_minor) &&
              ((req_acc & rd_q.access) != 3'd0);
    full_m  = used && type_ok &&
              (rd_q.major == daet_pkg::ANY_NUM || rd_q.major == req_major) &&
              (rd_q.minor == daet_pkg::ANY_NUM || rd_q.minor == req_minor) &&
              ((req_acc & ~rd_q.access) == 3'd0);
  end

  assign do_insert = is_add && (req_acc != 3'd0) && !hit && free_found;

  // one write port: wipe, scan write-back and insert never overlap
  always_comb begin
    we = 1'b0;
    wa = addr;
    wd = rd_q;
    priority if (ctrl.wipe_wr) begin
      we        = 1'b1;
      wa        = addr;
      wd        = '0;
    end else if (eval_vld && key_eq && (is_add || is_remove)) begin
      we        = 1'b1;
      wa        = eval_addr;
      wd        = rd_q;
      wd.access = is_add ? (rd_q.access | req_acc) : (rd_q.access & ~req_acc);
    end else if (ctrl.finish && do_insert) begin
      we        = 1'b1;
      wa        = free_idx;
      wd.typ    = req_type;
      wd.major  = req_major;
      wd.minor  = req_minor;
      wd.access = req_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctrl.scan_rd) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    eval_addr <= addr;
    if (ctrl.load) begin
      req_cmd     <= cmd;
      req_type    <= dev_type;
      req_major   <= major_num;
      req_minor   <= minor_num;
      req_acc     <= access_mask;
      hit         <= 1'b0;
      free_found  <= 1'b0;
      free_idx    <= '0;
      any_partial <= 1'b0;
      any_full    <= 1'b0;
    end else if (eval_vld) begin
      if (key_eq) begin
        hit <= 1'b1;
      end
      // keep the lowest free slot
      if (!used && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= eval_addr;
      end
      if (part_m) begin
        any_partial <= 1'b1;
      end
      if (full_m) begin
        any_full <= 1'b1;
      end
    end
    if (ctrl.finish) begin
      status  <= is_add && (req_acc != 3'd0) && !hit && !free_found;
      allowed <= (req_cmd == daet_pkg::CMD_CHECK) &&
                 (default_allow ? !any_partial : any_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      eval_vld <= ctrl.scan_rd;
      done     <= ctrl.finish;
    end
  end

endmodule
`default_nettype wire

// File: rtl/device_access_exception_table_unit.sv
// Top level of the device access exception table: APB policy register,
// controller and datapath. Depends on daet_pkg, daet_ctrl, daet_datapath.
//
//   channel   signals                                        direction  handshake
//   command   start, cmd, dev_type, major_num, minor_num,    in         start & !busy
//             access_mask
//   result    done, status, allowed                          out        done, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,          in/out     APB, pready = 1
//             prdata, pready
//
// Add, remove and check sweep the entry memory one entry per cycle: a read of
// every entry, a drain state for the registered read, then a finish state, with
// busy high throughout. Clear writes every entry free, then runs the finish
// state. The result strobe done is high in the first cycle that busy reads low.
// After reset the block clears the memory with busy high. Results cannot be
// stalled.
`default_nettype none
module device_access_exception_table_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [1:0]  dev_type,
  input  wire logic [31:0] major_num,
  input  wire logic [31:0] minor_num,
  input  wire logic [2:0]  access_mask,
  output logic             done,
  output logic             status,
  output logic             allowed,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  daet_pkg::ctrl_cmd_t ctrl;
  logic [AW-1:0]       addr;
  logic                default_allow;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {31'd0, default_allow} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_allow <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      default_allow <= pwdata[0];
    end
  end

  daet_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .ctrl  (ctrl),
    .addr  (addr)
  );

  daet_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .addr          (addr),
    .default_allow (default_allow),
    .cmd           (cmd),
    .dev_type      (dev_type),
    .major_num     (major_num),
    .minor_num     (minor_num),
    .access_mask   (access_mask),
    .done          (done),
    .status        (status),
    .allowed       (allowed)
  );

endmodule
`default_nettype wire

// File: rtl/daet_checker.sv
// Port-level checks for the exception table unit, attached by bind.
// Depends on daet_pkg and the top level's ports.
`default_nettype none
module daet_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] cmd,
  input wire logic       done,
  input wire logic       status,
  input wire logic       allowed
);

  logic [1:0] last_cmd;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      last_cmd <= cmd;
    end
  end

  // memory wipe runs right after reset
  a_reset_wipe: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_status_add: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (last_cmd == daet_pkg::CMD_ADD) && !allowed)
    else $error("table-full status on a non-add transaction");

endmodule

bind device_access_exception_table_unit daet_checker u_daet_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .cmd     (cmd),
  .done    (done),
  .status  (status),
  .allowed (allowed)
);
`default_nettype wire
